[hdl/cad16_pkg.sv]
// Shared constants and the tree node arithmetic for the averaging decimator.
`default_nettype none

package cad16_pkg;

    localparam int SAMPLE_W            = 8;
    localparam int TDATA_W             = 2 * SAMPLE_W;
    localparam int DEFAULT_TREE_LEVELS = 4;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam logic signed [SAMPLE_W:0] SUM_MAX = 9'sd127;
    localparam logic signed [SAMPLE_W:0] SUM_MIN = -9'sd128;

    // (a >>> 1) + (b >>> 1), clipped to the signed 8-bit range
    function automatic sample_t node_combine(input sample_t a, input sample_t b);
        logic signed [SAMPLE_W:0] sum;
        sample_t                  res;
        sum = $signed({{2{a[SAMPLE_W-1]}}, a[SAMPLE_W-1:1]})
            + $signed({{2{b[SAMPLE_W-1]}}, b[SAMPLE_W-1:1]});
        if (sum > SUM_MAX)
        begin
            res = SUM_MAX[SAMPLE_W-1:0];
        end
        else if (sum < SUM_MIN)
        begin
            res = SUM_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            res = sum[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[hdl/complex_average_decimator_16.sv]
// Averaging decimator: one complex result per 2^TREE_LEVELS complex input samples.
//
// Usage
//   Input stream (s_*): one complex sample per transfer, real part in
//   s_tdata[7:0], imaginary part in s_tdata[15:8], both two's complement.
//   Output stream (m_*): one complex average per group of 2^TREE_LEVELS
//   (16 by default) consecutive input transfers, same packing.
//   Each result is the root of a binary tree over the group; every node is
//   (left >>> 1) + (right >>> 1). Real and imaginary parts are independent.
// Throughput: one input transfer per cycle, sustained, with m_tready high.
// Path: the group's last sample is transferred into the input register,
//   then its result into the result register, where m_tvalid rises.
//   The work per sample is one pass through at most TREE_LEVELS node adders
//   between those two registers.
// Reset: clears the group position and both valid flags; the next sample
//   transferred starts a new group. Parked node values need no reset.
// Stall: while m_tready is low, a finished result is held in the result
//   register and input transfers keep flowing until the next group-closing
//   sample reaches the input register; that sample waits there and s_tready
//   drops until the held result is taken.
`default_nettype none

module complex_average_decimator_16 #(
    parameter int TREE_LEVELS = cad16_pkg::DEFAULT_TREE_LEVELS
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire  [cad16_pkg::TDATA_W-1:0] s_tdata,  // [7:0] sample_real, [15:8] sample_imag
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [cad16_pkg::TDATA_W-1:0] m_tdata   // [7:0] avg_real, [15:8] avg_imag
);

    import cad16_pkg::*;

    localparam logic [TREE_LEVELS-1:0] PHASE_LAST = '1;

    // input register
    logic                   st_valid_reg, st_valid_next;
    sample_t                st_real_reg, st_imag_reg;

    // group position; bit l set means level l holds a parked node
    logic [TREE_LEVELS-1:0] phase_reg, phase_next;
    sample_t                pend_real_reg [TREE_LEVELS];
    sample_t                pend_imag_reg [TREE_LEVELS];

    // result register
    logic                   out_valid_reg, out_valid_next;
    sample_t                out_real_reg, out_imag_reg;

    logic                   in_xfer;
    logic                   st_adv;
    logic                   st_last;
    logic                   out_load;
    logic [TREE_LEVELS-1:0] park_en;
    sample_t                acc_real, acc_imag;

    assign st_last  = (phase_reg == PHASE_LAST);
    // a group-closing sample may only move on if the result register frees up
    assign st_adv   = st_valid_reg && (!st_last || !out_valid_reg || m_tready);
    assign s_tready = !st_valid_reg || st_adv;
    assign in_xfer  = s_tvalid && s_tready;
    assign out_load = st_adv && st_last;

    // walk up the tree: combine with parked nodes until a free level is found
    always_comb
    begin
        logic parked;
        parked   = 1'b0;
        park_en  = '0;
        acc_real = st_real_reg;
        acc_imag = st_imag_reg;
        for (int lv = 0; lv < TREE_LEVELS; lv++)
        begin
            if (!parked)
            begin
                if (!phase_reg[lv])
                begin
                    park_en[lv] = 1'b1;
                    parked      = 1'b1;
                end
                else
                begin
                    acc_real = node_combine(pend_real_reg[lv], acc_real);
                    acc_imag = node_combine(pend_imag_reg[lv], acc_imag);
                end
            end
        end
    end

    always_comb
    begin
        st_valid_next  = in_xfer ? 1'b1 : (st_adv ? 1'b0 : st_valid_reg);
        phase_next     = st_adv ? phase_reg + 1'b1 : phase_reg;
        out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= 1'b0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg  <= st_valid_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            st_real_reg <= s_tdata[SAMPLE_W-1:0];
            st_imag_reg <= s_tdata[TDATA_W-1:SAMPLE_W];
        end
        if (out_load)
        begin
            out_real_reg <= acc_real;
            out_imag_reg <= acc_imag;
        end
        for (int lv = 0; lv < TREE_LEVELS; lv++)
        begin
            if (st_adv && park_en[lv])
            begin
                pend_real_reg[lv] <= acc_real;
                pend_imag_reg[lv] <= acc_imag;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_imag_reg, out_real_reg};

`ifndef SYNTHESIS
    // a fresh result only ever comes from a group-closing sample
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(st_valid_reg && st_last))
    else $error("result raised without a group-closing sample");

    // the group position moves by one for every sample that leaves the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        st_adv |=> phase_reg == $past(phase_reg) + 1'b1)
    else $error("group position did not advance");

    // a held result is never overwritten by the next group
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready && st_valid_reg && st_last) |-> !st_adv)
    else $error("held result overwritten");
`endif

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the complex averaging decimator by sixteen.
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import cad16_pkg::*;

    localparam int LEVELS      = DEFAULT_TREE_LEVELS;
    localparam int RAND_ITEMS  = 1200;
    localparam int CYCLE_LIMIT = 200000;  // far above the slowest legal run
    localparam int HOLD_CYCLES = 400;     // long output back-pressure stretch
    localparam int TAIL_CYCLES = 8;       // covers the two-register latency

    // Mirror of the decimator: parked node values per level, group position,
    // and the queue of averages still to come out of the block.
    class avg_scoreboard;
        sample_t           held_re [LEVELS];
        sample_t           held_im [LEVELS];
        logic [LEVELS-1:0] phase;
        sample_t           avg_re_q [$];
        sample_t           avg_im_q [$];
        int                mismatches;
        int                results_seen;

        function new();
            phase        = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        // (a >>> 1) + (b >>> 1), clipped to 8 bits (never clips in practice)
        function sample_t halve_and_add(sample_t a, sample_t b);
            logic signed [SAMPLE_W:0] sum;
            sum = (a >>> 1) + (b >>> 1);
            if (sum > 9'sd127)
                return 8'sd127;
            if (sum < -9'sd128)
                return -8'sd128;
            return sum[SAMPLE_W-1:0];
        endfunction

        // Called on every accepted input transfer.
        function void note_sample(sample_t re, sample_t im);
            sample_t           vr;
            sample_t           vi;
            logic [LEVELS-1:0] pos;
            vr    = re;
            vi    = im;
            pos   = phase;
            phase = phase + 1'b1;
            for (int lvl = 0; lvl < LEVELS; lvl++)
            begin
                if (!pos[lvl])
                begin
                    // partner not here yet: park the node at this level
                    held_re[lvl] = vr;
                    held_im[lvl] = vi;
                    return;
                end
                vr = halve_and_add(held_re[lvl], vr);
                vi = halve_and_add(held_im[lvl], vi);
            end
            avg_re_q.push_back(vr);
            avg_im_q.push_back(vi);
        endfunction

        function void flag(string what, sample_t want, sample_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch on %s: expected %0d, got %0d",
                         $realtime, what, want, got);
        endfunction

        // Called on every accepted output transfer.
        function void check_average(logic [TDATA_W-1:0] data);
            sample_t want_re;
            sample_t want_im;
            results_seen++;
            if (avg_re_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result 0x%04h", $realtime, data);
                return;
            end
            want_re = avg_re_q.pop_front();
            want_im = avg_im_q.pop_front();
            if (data[SAMPLE_W-1:0] !== want_re)
                flag("avg_real", want_re, data[SAMPLE_W-1:0]);
            if (data[TDATA_W-1:SAMPLE_W] !== want_im)
                flag("avg_imag", want_im, data[TDATA_W-1:SAMPLE_W]);
        endfunction

        function int outstanding();
            return avg_re_q.size();
        endfunction
    endclass

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;   // [7:0] sample_real, [15:8] sample_imag
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;         // [7:0] avg_real, [15:8] avg_imag

    avg_scoreboard sb = new();

    bit calm      = 1'b0;  // both sides stop idling while set
    bit hold_req  = 1'b0;  // asks the receiver for a long hold-off
    int hold_left = 0;
    int sent      = 0;
    int cycles    = 0;

    complex_average_decimator_16 DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d averages outstanding",
                         cycles, sb.outstanding());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Output side: values are sampled straight after the edge, so they are
    // the ones the block presented at that edge.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_average(m_tdata);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                // long hold-off: the block has to fill and stall its input
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (calm)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 34);
        end
    end

    // One input transfer, with random idle cycles in front of it. tvalid is
    // left high afterwards so back-to-back transfers need no extra edge.
    task automatic send_sample(input sample_t re, input sample_t im);
        while (!calm && $urandom_range(0, 99) < 34)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {im, re};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_sample(re, im);
        sent++;
    endtask

    // Stop offering and wait for every expected average to come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // Random sample with a bias towards the range ends, zero and minus one.
    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return -8'sd128;
            1:       return 8'sd127;
            2:       return 8'sd0;
            3:       return -8'sd1;
            default: return sample_t'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed group: real at the top end, imag at the bottom end, so
        // the tree works through the full positive and negative extremes.
        for (int i = 0; i < 16; i++)
            send_sample(8'sd127, -8'sd128);
        // Half a group swinging between the extremes on both parts.
        for (int i = 0; i < 8; i++)
        begin
            if (i[0])
                send_sample(-8'sd128, 8'sd127);
            else
                send_sample(8'sd127, -8'sd128);
        end

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            // a long stretch where neither side idles
            calm = (i >= 400 && i < 600);
            if (i == 700)
                hold_req = 1'b1;
            if (i == 900)
                drain_results();
            send_sample(pick_sample(), pick_sample());
        end
        calm = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d sample transfers and %0d averages, with a long",
                 sent, sb.results_seen);
        $display("output hold-off and a drain pause; %0d mismatches.", sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
hdl/cad16_pkg.sv
hdl/complex_average_decimator_16.sv
dv/testbench.sv
